// ----- hdl/sfla_pkg.sv -----
// Shared types and constants for the slot free-list allocator.
// No dependencies; every other file in hdl/ imports this package.
package sfla_pkg;

    localparam int CAP_W      = 7;   // capacity register width
    localparam int ID_W       = 31;  // request id width
    localparam int SLOT_W     = 6;   // stored slot number width
    localparam int OUT_SLOT_W = 7;   // signed slot field on the result channel
    localparam int REQ_W      = 2;
    localparam int STATUS_W   = 3;

    localparam logic [OUT_SLOT_W-1:0] SLOT_NONE = {OUT_SLOT_W{1'b1}};  // -1

    typedef enum logic [REQ_W-1:0] {
        REQ_ACQUIRE = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_LOOKUP  = 2'd2,
        REQ_NOP     = 2'd3
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_GRANTED  = 3'd0,
        STAT_HELD     = 3'd1,
        STAT_ALIASED  = 3'd2,
        STAT_NOT_HELD = 3'd3,
        STAT_CAP_ZERO = 3'd4,
        STAT_FULL     = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_FILL,
        ST_ALLOC,
        ST_POP,
        ST_MOD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [SLOT_W-1:0] slot;
    } holder_entry_t;

    typedef struct packed {
        logic          we;
        holder_entry_t entry;
    } holder_wr_t;

    typedef struct packed {
        logic            start;
        logic [ID_W-1:0] key;
    } scan_cmd_t;

    typedef struct packed {
        logic              done;
        logic              found;
        logic              empty_found;
        logic [SLOT_W-1:0] hit_slot;
    } scan_stat_t;

    typedef struct packed {
        logic              fill;
        logic              pop;
        logic              push;
        logic [SLOT_W-1:0] push_slot;
        logic [CAP_W-1:0]  cap;
    } stk_cmd_t;

    typedef struct packed {
        logic busy;
        logic filled;
        logic empty;
        logic full;
    } stk_stat_t;

endpackage

// ----- hdl/sfla_holder_table.sv -----
// Holder table: id -> slot memory with a one-entry-per-cycle scan comparator
// and a clearing pass after reset. Depends on sfla_pkg.
module sfla_holder_table #(
    parameter int  MAX_HOLDERS = 64,
    localparam int HA_W        = (MAX_HOLDERS > 1) ? $clog2(MAX_HOLDERS) : 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sfla_pkg::scan_cmd_t  scan_cmd,
    input  sfla_pkg::holder_wr_t wr,
    input  logic [HA_W-1:0]      waddr,
    output logic                 busy,
    output sfla_pkg::scan_stat_t stat,
    output logic [HA_W-1:0]      hit_idx,
    output logic [HA_W-1:0]      empty_idx
);
    import sfla_pkg::*;

    localparam int HC_W = $clog2(MAX_HOLDERS + 1);

    holder_entry_t     mem [MAX_HOLDERS];

    logic              clearing_reg;
    logic [HC_W-1:0]   clr_cnt_reg;
    logic              scan_reg;
    logic [HC_W-1:0]   cnt_reg;
    logic              rd_vld_reg;
    logic [HA_W-1:0]   rd_idx_reg;
    holder_entry_t     rd_data_reg;
    logic [ID_W-1:0]   key_reg;
    logic              found_reg;
    logic              empty_found_reg;
    logic              done_reg;
    logic [HA_W-1:0]   hit_idx_reg;
    logic [HA_W-1:0]   empty_idx_reg;
    logic [SLOT_W-1:0] hit_slot_reg;

    logic              mem_we;
    logic [HA_W-1:0]   mem_addr;
    holder_entry_t     mem_wdata;
    logic              match;

    // Clearing pass: invalidate one entry per cycle after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clearing_reg) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == HC_W'(MAX_HOLDERS - 1)) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // Write port: clearing pass wins, otherwise sequencer writes
    always_comb begin
        mem_we    = clearing_reg | wr.we;
        mem_addr  = clearing_reg ? clr_cnt_reg[HA_W-1:0] : waddr;
        mem_wdata = clearing_reg ? '0 : wr.entry;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
    end

    // Registered read, one address per scan cycle
    always_ff @(posedge aclk) begin
        if (scan_reg) begin
            rd_data_reg <= mem[cnt_reg[HA_W-1:0]];
        end
    end

    // Advance the scan address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg   <= 1'b0;
            cnt_reg    <= '0;
            rd_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            rd_vld_reg <= scan_reg;
            done_reg   <= rd_vld_reg && (rd_idx_reg == HA_W'(MAX_HOLDERS - 1));
            if (scan_cmd.start) begin
                scan_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (scan_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == HC_W'(MAX_HOLDERS - 1)) begin
                    scan_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= cnt_reg[HA_W-1:0];
        if (scan_cmd.start) begin
            key_reg <= scan_cmd.key;
        end
    end

    // Shared comparator: one entry per cycle
    assign match = rd_data_reg.valid && (rd_data_reg.id == key_reg);

    // Keep the first match and the first free entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg       <= 1'b0;
            empty_found_reg <= 1'b0;
        end else if (scan_cmd.start) begin
            found_reg       <= 1'b0;
            empty_found_reg <= 1'b0;
        end else if (rd_vld_reg) begin
            if (match && !found_reg) begin
                found_reg <= 1'b1;
            end
            if (!rd_data_reg.valid && !empty_found_reg) begin
                empty_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_vld_reg && match && !found_reg) begin
            hit_idx_reg  <= rd_idx_reg;
            hit_slot_reg <= rd_data_reg.slot;
        end
        if (rd_vld_reg && !rd_data_reg.valid && !empty_found_reg) begin
            empty_idx_reg <= rd_idx_reg;
        end
    end

    assign busy             = clearing_reg;
    assign stat.done        = done_reg;
    assign stat.found       = found_reg;
    assign stat.empty_found = empty_found_reg;
    assign stat.hit_slot    = hit_slot_reg;
    assign hit_idx          = hit_idx_reg;
    assign empty_idx        = empty_idx_reg;

endmodule

// ----- hdl/sfla_free_stack.sv -----
// Free-slot stack: LIFO memory with a count, a lazy fill sweep, push and pop.
// Depends on sfla_pkg.
module sfla_free_stack #(
    parameter int MAX_SLOTS = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  sfla_pkg::stk_cmd_t  cmd,
    output sfla_pkg::stk_stat_t stat,
    output logic [sfla_pkg::SLOT_W-1:0] pop_slot
);
    import sfla_pkg::*;

    localparam int SA_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SC_W = $clog2(MAX_SLOTS + 1);

    logic [SLOT_W-1:0] mem [MAX_SLOTS];

    logic [SC_W-1:0]   count_reg;
    logic              filled_reg;
    logic              fill_reg;
    logic [SA_W-1:0]   fill_k_reg;
    logic [CAP_W-1:0]  fill_val_reg;
    logic [CAP_W-1:0]  fill_cap_reg;
    logic [SLOT_W-1:0] pop_slot_reg;

    logic              mem_we;
    logic [SA_W-1:0]   mem_addr;
    logic [SLOT_W-1:0] mem_wdata;
    logic [SC_W-1:0]   count_dec;

    assign count_dec = count_reg - 1'b1;

    // Write port: fill sweep or push
    always_comb begin
        mem_we    = fill_reg | cmd.push;
        mem_addr  = fill_reg ? fill_k_reg : count_reg[SA_W-1:0];
        mem_wdata = fill_reg ? fill_val_reg[SLOT_W-1:0] : cmd.push_slot;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
    end

    // Pop reads the top entry; data is valid the next cycle
    always_ff @(posedge aclk) begin
        if (cmd.pop) begin
            pop_slot_reg <= mem[count_dec[SA_W-1:0]];
        end
    end

    // Fill sweep writes cap-1 down to 0, one entry per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg   <= 1'b0;
            filled_reg <= 1'b0;
            count_reg  <= '0;
        end else if (cmd.fill) begin
            fill_reg <= 1'b1;
        end else if (fill_reg) begin
            if (fill_val_reg == '0) begin
                fill_reg   <= 1'b0;
                filled_reg <= 1'b1;
                count_reg  <= SC_W'(fill_cap_reg);
            end
        end else if (cmd.pop) begin
            count_reg <= count_dec;
        end else if (cmd.push) begin
            count_reg <= count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fill) begin
            fill_k_reg   <= '0;
            fill_val_reg <= cmd.cap - 1'b1;
            fill_cap_reg <= cmd.cap;
        end else if (fill_reg) begin
            fill_k_reg   <= fill_k_reg + 1'b1;
            fill_val_reg <= fill_val_reg - 1'b1;
        end
    end

    assign stat.busy   = fill_reg;
    assign stat.filled = filled_reg;
    assign stat.empty  = (count_reg == '0);
    assign stat.full   = (count_reg >= SC_W'(MAX_SLOTS));
    assign pop_slot    = pop_slot_reg;

endmodule

// ----- hdl/sfla_mod_unit.sv -----
// Bit-serial restoring remainder unit: request id modulo capacity,
// one dividend bit per cycle. Depends on sfla_pkg.
module sfla_mod_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [sfla_pkg::ID_W-1:0]   dividend,
    input  logic [sfla_pkg::CAP_W-1:0]  divisor,
    output logic                        busy,
    output logic                        done,
    output logic [sfla_pkg::SLOT_W-1:0] rem
);
    import sfla_pkg::*;

    localparam int STEP_W = $clog2(ID_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [ID_W-1:0]   dvd_reg;
    logic [CAP_W-1:0]  dsr_reg;
    logic [CAP_W-1:0]  rem_reg;

    logic [CAP_W:0]    trial;
    logic [CAP_W:0]    diff;
    logic [CAP_W-1:0]  rem_next;

    // Shift in the next dividend bit, subtract when it fits
    always_comb begin
        trial    = {rem_reg, dvd_reg[ID_W-1]};
        diff     = trial - {1'b0, dsr_reg};
        rem_next = (trial >= {1'b0, dsr_reg}) ? diff[CAP_W-1:0] : trial[CAP_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(ID_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= rem_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign rem  = rem_reg[SLOT_W-1:0];

endmodule

// ----- hdl/slot_free_list_allocator.sv -----
// Slot free-list allocator top level: request sequencer, output register
// and instances of sfla_holder_table, sfla_free_stack and sfla_mod_unit.
//
// Usage:
//   Input channel s_valid/s_ready carries one request beat (s_req_type,
//   s_request_id). Result channel m_valid/m_ready carries one result beat
//   (m_slot, m_status) per request. cfg_we/cfg_wdata writes the slot
//   capacity; write it only while no request is in flight.
//   Each request scans the holder table one entry per cycle through a single
//   id comparator before a lookup, a release or a held or refused acquire
//   puts its result beat out. A grant popped from the stack also passes
//   through the ALLOC and POP states, a full holder table through ALLOC, the
//   first acquire that needs a new slot waits in FILL for the stack fill
//   sweep, and an aliased fallback waits in MOD for the bit-serial remainder
//   unit (31 dividend bits). One request is in flight at a time; s_ready
//   returns once the result is in the output register, so the next request
//   may be accepted while that result still waits for m_ready.
//   After reset the holder table runs a clearing pass over all MAX_HOLDERS
//   entries with s_ready low. If the receiver stalls, the result holds in
//   the output register and the sequencer waits with its own result until
//   it drains.
module slot_free_list_allocator #(
    parameter int MAX_SLOTS   = 64,
    parameter int MAX_HOLDERS = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [6:0]        cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_req_type,
    input  logic [30:0]       s_request_id,
    output logic              m_valid,
    input  logic              m_ready,
    output logic signed [6:0] m_slot,
    output logic [2:0]        m_status
);
    import sfla_pkg::*;

    localparam int HA_W = (MAX_HOLDERS > 1) ? $clog2(MAX_HOLDERS) : 1;

    state_t                state_reg, state_next;
    logic [CAP_W-1:0]      cap_reg;
    logic [CAP_W-1:0]      cap_eff;
    logic [CAP_W-1:0]      cap_eff_reg;
    req_type_t             req_type_reg;
    logic [ID_W-1:0]       req_id_reg;
    logic [OUT_SLOT_W-1:0] res_slot_reg, res_slot_next;
    status_t               res_status_reg, res_status_next;
    logic                  m_valid_reg;
    logic [OUT_SLOT_W-1:0] m_slot_reg;
    status_t               m_status_reg;
    logic                  load_out;
    logic                  accept;

    scan_cmd_t             scan_cmd;
    scan_stat_t            scan_stat;
    holder_wr_t            hold_wr;
    logic [HA_W-1:0]       hold_waddr;
    logic                  hold_busy;
    logic [HA_W-1:0]       hit_idx;
    logic [HA_W-1:0]       empty_idx;

    stk_cmd_t              stk_cmd;
    stk_stat_t             stk_stat;
    logic [SLOT_W-1:0]     pop_slot;

    logic                  mod_start;
    logic                  mod_busy;
    logic                  mod_done;
    logic [SLOT_W-1:0]     mod_rem;

    // Capacity register, saturated to the stack depth
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= '0;
        end else if (cfg_we) begin
            cap_reg <= cfg_wdata;
        end
    end

    assign cap_eff = (int'(cap_reg) > MAX_SLOTS) ? CAP_W'(MAX_SLOTS) : cap_reg;

    assign s_ready = (state_reg == ST_IDLE) && !hold_busy;
    assign accept  = s_valid && s_ready;

    // Latch the request beat
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_type_reg <= req_type_t'(s_req_type);
            req_id_reg   <= s_request_id;
            cap_eff_reg  <= cap_eff;
        end
    end

    sfla_holder_table #(
        .MAX_HOLDERS (MAX_HOLDERS)
    ) u_holders (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .scan_cmd  (scan_cmd),
        .wr        (hold_wr),
        .waddr     (hold_waddr),
        .busy      (hold_busy),
        .stat      (scan_stat),
        .hit_idx   (hit_idx),
        .empty_idx (empty_idx)
    );

    sfla_free_stack #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_stack (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (stk_cmd),
        .stat     (stk_stat),
        .pop_slot (pop_slot)
    );

    sfla_mod_unit u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mod_start),
        .dividend (req_id_reg),
        .divisor  (cap_eff_reg),
        .busy     (mod_busy),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // Sequencer state register and result holding registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_slot_reg   <= res_slot_next;
        res_status_reg <= res_status_next;
    end

    // Next state, commands to the units, result selection
    always_comb begin
        state_next        = state_reg;
        res_slot_next     = res_slot_reg;
        res_status_next   = res_status_reg;
        scan_cmd.start    = 1'b0;
        scan_cmd.key      = s_request_id;
        hold_wr.we        = 1'b0;
        hold_wr.entry     = '0;
        hold_waddr        = empty_idx;
        stk_cmd.fill      = 1'b0;
        stk_cmd.pop       = 1'b0;
        stk_cmd.push      = 1'b0;
        stk_cmd.push_slot = scan_stat.hit_slot;
        stk_cmd.cap       = cap_eff_reg;
        mod_start         = 1'b0;
        load_out          = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    scan_cmd.start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_stat.done) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                state_next = ST_DONE;
                unique case (req_type_reg)
                    REQ_ACQUIRE: begin
                        if (cap_eff_reg == '0) begin
                            res_slot_next   = '0;
                            res_status_next = STAT_CAP_ZERO;
                        end else if (scan_stat.found) begin
                            res_slot_next   = {1'b0, scan_stat.hit_slot};
                            res_status_next = STAT_HELD;
                        end else if (!stk_stat.filled) begin
                            stk_cmd.fill = 1'b1;
                            state_next   = ST_FILL;
                        end else begin
                            state_next = ST_ALLOC;
                        end
                    end
                    REQ_RELEASE: begin
                        if (scan_stat.found) begin
                            // Forget the id; push back unless the stack is full
                            hold_wr.we    = 1'b1;
                            hold_waddr    = hit_idx;
                            res_slot_next = {1'b0, scan_stat.hit_slot};
                            if (stk_stat.full) begin
                                res_status_next = STAT_FULL;
                            end else begin
                                stk_cmd.push    = 1'b1;
                                res_status_next = STAT_HELD;
                            end
                        end else begin
                            res_slot_next   = SLOT_NONE;
                            res_status_next = STAT_NOT_HELD;
                        end
                    end
                    REQ_LOOKUP: begin
                        if (scan_stat.found) begin
                            res_slot_next   = {1'b0, scan_stat.hit_slot};
                            res_status_next = STAT_HELD;
                        end else begin
                            res_slot_next   = SLOT_NONE;
                            res_status_next = STAT_NOT_HELD;
                        end
                    end
                    REQ_NOP: begin
                        res_slot_next   = SLOT_NONE;
                        res_status_next = STAT_NOT_HELD;
                    end
                    default: begin
                        res_slot_next   = SLOT_NONE;
                        res_status_next = STAT_NOT_HELD;
                    end
                endcase
            end
            ST_FILL: begin
                if (!stk_stat.busy) begin
                    state_next = ST_ALLOC;
                end
            end
            ST_ALLOC: begin
                if (!scan_stat.empty_found) begin
                    res_slot_next   = SLOT_NONE;
                    res_status_next = STAT_FULL;
                    state_next      = ST_DONE;
                end else if (!stk_stat.empty) begin
                    stk_cmd.pop = 1'b1;
                    state_next  = ST_POP;
                end else begin
                    mod_start  = 1'b1;
                    state_next = ST_MOD;
                end
            end
            ST_POP: begin
                hold_wr.we          = 1'b1;
                hold_wr.entry.valid = 1'b1;
                hold_wr.entry.id    = req_id_reg;
                hold_wr.entry.slot  = pop_slot;
                res_slot_next       = {1'b0, pop_slot};
                res_status_next     = STAT_GRANTED;
                state_next          = ST_DONE;
            end
            ST_MOD: begin
                if (mod_done) begin
                    hold_wr.we          = 1'b1;
                    hold_wr.entry.valid = 1'b1;
                    hold_wr.entry.id    = req_id_reg;
                    hold_wr.entry.slot  = mod_rem;
                    res_slot_next       = {1'b0, mod_rem};
                    res_status_next     = STAT_ALIASED;
                    state_next          = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: load a result beat, drop it when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_slot_reg   <= res_slot_reg;
            m_status_reg <= res_status_reg;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_slot   = m_slot_reg;
    assign m_status = m_status_reg;

`ifndef ASSERT_OFF
    a_mod_only_in_mod_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_busy |-> (state_reg == ST_MOD))
        else $error("remainder unit busy outside its state");

    a_fill_only_in_fill_state: assert property (@(posedge aclk) disable iff (!aresetn)
        stk_stat.busy |-> (state_reg == ST_FILL))
        else $error("stack fill sweep outside its state");

    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        stk_cmd.pop |-> !stk_stat.empty)
        else $error("pop issued on an empty stack");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        stk_cmd.push |-> !stk_stat.full)
        else $error("push issued on a full stack");
`endif

endmodule
